FILE: src/fsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsg_pkg;

    // Default grid size and fixed field widths.
    localparam int GRID_LAST_COLUMN_DEF = 63;
    localparam int GRID_LAST_ROW_DEF    = 63;
    localparam int FUNC_W               = 2;
    localparam int XY_W                 = 6;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_STEP  = 2'd0,
        FUNC_PLACE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } fsg_func_t;

    // Control strobes from the engine to the column memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } fsg_mem_ctl_t;

    // Finished result offered by the engine to the output stage.
    typedef struct packed {
        logic valid;
        logic cell_value;
        logic placed;
    } fsg_res_t;

endpackage

`default_nettype wire

FILE: src/fsg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fsg_req_if import fsg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;

    modport source (output valid, output func, output x, output y, input ready);
    modport sink   (input valid, input func, input x, input y, output ready);
endinterface

`default_nettype wire

FILE: src/fsg_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fsg_rsp_if;
    logic valid;
    logic ready;
    logic cell_value;
    logic placed;

    modport source (output valid, output cell_value, output placed, input ready);
    modport sink   (input valid, input cell_value, input placed, output ready);
endinterface

`default_nettype wire

FILE: src/fsg_col_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Column store: one word per grid column, one bit per row. A per-column
// valid bit makes a never-written column read as empty.
module fsg_col_mem import fsg_pkg::*;
#(
    parameter int LAST_COLUMN = GRID_LAST_COLUMN_DEF,
    parameter int LAST_ROW    = GRID_LAST_ROW_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fsg_mem_ctl_t                        ctl,
    input  wire logic [$clog2(LAST_COLUMN+1)-1:0]    rd_addr,
    input  wire logic [$clog2(LAST_COLUMN+1)-1:0]    wr_addr,
    input  wire logic [LAST_ROW:0]                   wr_data,
    output logic      [LAST_ROW:0]                   rd_data
);

    localparam int DEPTH = LAST_COLUMN + 1;

    logic [LAST_ROW:0] mem [DEPTH];
    logic [LAST_ROW:0] rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    // The engine never reads and writes the same column in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en && ctl.wr_en |-> rd_addr != wr_addr)
        else $error("column read and write collide");

    // A clear never coincides with a read or a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !ctl.wr_en && !ctl.rd_en)
        else $error("clear overlaps a memory access");

    // Every write stays inside the grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> int'(wr_addr) <= LAST_COLUMN)
        else $error("write address beyond last column");

endmodule

`default_nettype wire

FILE: src/fsg_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: decodes requests, runs place as a read-modify-write and read as
// a read of one column, clears through the memory, and sweeps a three-column
// window through the memory for a generation step, one row per cycle.
module fsg_engine import fsg_pkg::*;
#(
    parameter int LAST_COLUMN = GRID_LAST_COLUMN_DEF,
    parameter int LAST_ROW    = GRID_LAST_ROW_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    input  wire logic [FUNC_W-1:0]                   req_func,
    input  wire logic [XY_W-1:0]                     req_x,
    input  wire logic [XY_W-1:0]                     req_y,
    output logic                                     req_ready,
    output fsg_res_t                                 res,
    input  wire logic                                res_ready,
    output fsg_mem_ctl_t                             mem_ctl,
    output logic      [$clog2(LAST_COLUMN+1)-1:0]    mem_rd_addr,
    output logic      [$clog2(LAST_COLUMN+1)-1:0]    mem_wr_addr,
    output logic      [LAST_ROW:0]                   mem_wr_data,
    input  wire logic [LAST_ROW:0]                   mem_rd_data
);

    localparam int COL_W = $clog2(LAST_COLUMN + 1);
    localparam int ROW_W = $clog2(LAST_ROW + 1);
    localparam int ROWS_N = LAST_ROW + 1;
    localparam bit HAS_ROWS = (LAST_ROW > 2);
    localparam logic [ROW_W-1:0] ROW_START = ROW_W'(LAST_ROW - 2);
    localparam logic [ROW_W-1:0] ROW_ONE   = ROW_W'(1);
    localparam logic [COL_W-1:0] COL_ONE   = COL_W'(1);
    localparam logic [COL_W-1:0] COL_TWO   = COL_W'(2);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_ACCESS    = 9'b000000010,
        ST_LOAD      = 9'b000000100,
        ST_ROWS      = 9'b000001000,
        ST_NEXT      = 9'b000010000,
        ST_FILL      = 9'b000100000,
        ST_TAIL_CUR  = 9'b001000000,
        ST_TAIL_LEFT = 9'b010000000,
        ST_RESULT    = 9'b100000000
    } fsg_state_t;

    localparam logic [1:0] LD_RIGHT = 2'd0;
    localparam logic [1:0] LD_CUR   = 2'd1;
    localparam logic [1:0] LD_LEFT  = 2'd2;

    fsg_state_t        state_reg, state_next;
    fsg_func_t         op_reg, op_next;
    logic              hit_reg, hit_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  bit_reg, bit_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [1:0]        ld_cnt_reg, ld_cnt_next;
    logic [ROWS_N-1:0] left_reg, left_next;
    logic [ROWS_N-1:0] cur_reg, cur_next;
    logic [ROWS_N-1:0] right_reg, right_next;
    logic              cell_reg, cell_next;
    logic              placed_reg, placed_next;

    logic              place_ok;
    logic              read_ok;
    logic [ROW_W-1:0]  row_dn;

    assign read_ok  = (int'(req_x) <= LAST_COLUMN) && (int'(req_y) <= LAST_ROW);
    assign place_ok = read_ok && (req_x != '0) && (req_y != '0);
    assign row_dn   = row_reg + ROW_ONE;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        hit_next    = hit_reg;
        col_next    = col_reg;
        bit_next    = bit_reg;
        row_next    = row_reg;
        ld_cnt_next = ld_cnt_reg;
        left_next   = left_reg;
        cur_next    = cur_reg;
        right_next  = right_reg;
        cell_next   = cell_reg;
        placed_next = placed_reg;
        mem_ctl     = '0;
        mem_rd_addr = col_reg;
        mem_wr_addr = col_reg;
        mem_wr_data = cur_reg;
        req_ready   = 1'b0;
        res         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next     = fsg_func_t'(req_func);
                    col_next    = COL_W'(req_x);
                    bit_next    = ROW_W'(req_y);
                    cell_next   = 1'b0;
                    placed_next = 1'b0;
                    case (fsg_func_t'(req_func))
                        FUNC_STEP:
                        begin
                            if (HAS_ROWS)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_rd_addr   = COL_W'(LAST_COLUMN);
                                col_next      = COL_W'(LAST_COLUMN - 1);
                                ld_cnt_next   = LD_RIGHT;
                                state_next    = ST_LOAD;
                            end
                            else
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        FUNC_PLACE:
                        begin
                            hit_next      = place_ok;
                            mem_ctl.rd_en = place_ok;
                            mem_rd_addr   = COL_W'(req_x);
                            state_next    = ST_ACCESS;
                        end
                        FUNC_CLEAR:
                        begin
                            mem_ctl.clear = 1'b1;
                            state_next    = ST_RESULT;
                        end
                        FUNC_READ:
                        begin
                            hit_next      = read_ok;
                            mem_ctl.rd_en = read_ok;
                            mem_rd_addr   = COL_W'(req_x);
                            state_next    = ST_ACCESS;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_ACCESS:
            begin
                if (op_reg == FUNC_PLACE)
                begin
                    placed_next   = hit_reg;
                    mem_ctl.wr_en = hit_reg;
                    mem_wr_addr   = col_reg;
                    mem_wr_data   = mem_rd_data | (ROWS_N'(1) << bit_reg);
                end
                else
                begin
                    cell_next = hit_reg & mem_rd_data[bit_reg];
                end
                state_next = ST_RESULT;
            end

            ST_LOAD:
            begin
                ld_cnt_next = ld_cnt_reg + 2'd1;
                case (ld_cnt_reg)
                    LD_RIGHT:
                    begin
                        right_next    = mem_rd_data;
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = col_reg;
                    end
                    LD_CUR:
                    begin
                        cur_next      = mem_rd_data;
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = col_reg - COL_ONE;
                    end
                    LD_LEFT:
                    begin
                        left_next  = mem_rd_data;
                        row_next   = ROW_START;
                        state_next = ST_ROWS;
                    end
                    default:
                    begin
                        state_next = ST_ROWS;
                    end
                endcase
            end

            ST_ROWS:
            begin
                if (cur_reg[row_reg])
                begin
                    if (!cur_reg[row_dn])
                    begin
                        cur_next[row_reg] = 1'b0;
                        cur_next[row_dn]  = 1'b1;
                    end
                    else if (!left_reg[row_dn])
                    begin
                        cur_next[row_reg] = 1'b0;
                        left_next[row_dn] = 1'b1;
                    end
                    else if (!right_reg[row_dn])
                    begin
                        cur_next[row_reg]  = 1'b0;
                        right_next[row_dn] = 1'b1;
                    end
                end
                if (row_reg == ROW_ONE)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    row_next = row_reg - ROW_ONE;
                end
            end

            ST_NEXT:
            begin
                // The right column can no longer change: retire it.
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = col_reg + COL_ONE;
                mem_wr_data   = right_reg;
                if (col_reg != COL_ONE)
                begin
                    right_next    = cur_reg;
                    cur_next      = left_reg;
                    mem_ctl.rd_en = 1'b1;
                    mem_rd_addr   = col_reg - COL_TWO;
                    col_next      = col_reg - COL_ONE;
                    state_next    = ST_FILL;
                end
                else
                begin
                    state_next = ST_TAIL_CUR;
                end
            end

            ST_FILL:
            begin
                left_next  = mem_rd_data;
                row_next   = ROW_START;
                state_next = ST_ROWS;
            end

            ST_TAIL_CUR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = col_reg;
                mem_wr_data   = cur_reg;
                state_next    = ST_TAIL_LEFT;
            end

            ST_TAIL_LEFT:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = col_reg - COL_ONE;
                mem_wr_data   = left_reg;
                state_next    = ST_RESULT;
            end

            ST_RESULT:
            begin
                res.valid      = 1'b1;
                res.cell_value = cell_reg;
                res.placed     = placed_reg;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        hit_reg    <= hit_next;
        col_reg    <= col_next;
        bit_reg    <= bit_next;
        row_reg    <= row_next;
        ld_cnt_reg <= ld_cnt_next;
        left_reg   <= left_next;
        cur_reg    <= cur_next;
        right_reg  <= right_next;
        cell_reg   <= cell_next;
        placed_reg <= placed_next;
    end

    // The row sweep never touches the top border row or the two bottom rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROWS |-> row_reg != '0 && int'(row_reg) <= LAST_ROW - 2)
        else $error("row sweep outside the movable rows");

    // The window center stays on an inner column during the sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROWS |-> col_reg != '0 && int'(col_reg) < LAST_COLUMN)
        else $error("window center on a border column");

    // A step always offers its result right after column zero is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAIL_LEFT |=> state_reg == ST_RESULT)
        else $error("step did not complete after the last write-back");

endmodule

`default_nettype wire

FILE: src/falling_sand_grid_step.sv
// Place and read pass through the idle, access and result states, clear
// through idle and result only. A step loads three columns and then sweeps
// the rows, one row update per cycle; the column memory has a single read
// and a single write port. The engine takes a new request only after it has
// handed its previous result to the output register, which frees the engine.
// Reset empties the grid.
`timescale 1ns / 1ps
`default_nettype none

// Falling-sand grid. The grid lives in a column memory, one word per column
// and one bit per row. Place is one read-modify-write of a column, read one
// read. A step slides a window of three column registers (left, center,
// right) from the right edge to the left edge of the grid; within the center
// column the rows are updated bottom to top, one per cycle. When the window
// moves one column left, the old right column is written back, since no
// later grain can land in it. A grain that falls below-left lands in the new
// center column and is visited again, exactly as the in-place scan requires.
//
// Clear and reset drop the per-column valid bits of the memory, so an
// unwritten column reads as empty and no clearing pass is needed.
module falling_sand_grid_step import fsg_pkg::*;
#(
    parameter int GRID_LAST_COLUMN = GRID_LAST_COLUMN_DEF,
    parameter int GRID_LAST_ROW    = GRID_LAST_ROW_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsg_req_if.sink    req,
    fsg_rsp_if.source  rsp
);

    localparam int COL_W = $clog2(GRID_LAST_COLUMN + 1);

    fsg_mem_ctl_t         mem_ctl;
    logic [COL_W-1:0]     mem_rd_addr;
    logic [COL_W-1:0]     mem_wr_addr;
    logic [GRID_LAST_ROW:0] mem_wr_data;
    logic [GRID_LAST_ROW:0] mem_rd_data;

    fsg_res_t             res;
    logic                 res_ready;

    // Output register: holds one response so the engine can go back to idle
    // and take the next request while the consumer stalls.
    logic                 rsp_valid_reg;
    logic                 rsp_cell_reg;
    logic                 rsp_placed_reg;

    fsg_col_mem #(
        .LAST_COLUMN (GRID_LAST_COLUMN),
        .LAST_ROW    (GRID_LAST_ROW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    fsg_engine #(
        .LAST_COLUMN (GRID_LAST_COLUMN),
        .LAST_ROW    (GRID_LAST_ROW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_func    (req.func),
        .req_x       (req.x),
        .req_y       (req.y),
        .req_ready   (req.ready),
        .res         (res),
        .res_ready   (res_ready),
        .mem_ctl     (mem_ctl),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    // The engine may hand over a result whenever the register is empty or
    // is being emptied in this cycle.
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            rsp_cell_reg   <= res.cell_value;
            rsp_placed_reg <= res.placed;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cell_value = rsp_cell_reg;
    assign rsp.placed     = rsp_placed_reg;

endmodule

`default_nettype wire

FILE: tb/falling_sand_grid_step_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the falling-sand grid.
//
// Every request that the block accepts is run through a local copy of the
// grid at the moment of acceptance. The expected response goes into a FIFO,
// and a separate process compares each accepted response with the oldest
// entry. Since the block answers every request exactly once and in order,
// the FIFO head always belongs to the response on the bus.
module falling_sand_grid_step_tb;
    import fsg_pkg::*;

    localparam int LAST_COL = GRID_LAST_COLUMN_DEF;
    localparam int LAST_ROW = GRID_LAST_ROW_DEF;

    // Expected response fields for one request.
    typedef struct packed {
        logic cell_value;
        logic placed;
    } sand_reply_t;

    logic clk;
    logic rst_n;

    fsg_req_if req_ch ();
    fsg_rsp_if rsp_ch ();

    falling_sand_grid_step #(
        .GRID_LAST_COLUMN (LAST_COL),
        .GRID_LAST_ROW    (LAST_ROW)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Local grid image, one word per column and one bit per row, matching
    // the way the block stores it. Indexed as sand_cols[column][row].
    bit [LAST_ROW:0] sand_cols [0:LAST_COL];

    sand_reply_t pending_replies [$];

    // Idle and stall percentages for the current phase.
    int sender_idle_pct = 0;
    int rsp_stall_pct   = 0;
    // Remaining cycles of a forced hold-off on the response side.
    int rsp_hold_left   = 0;

    int error_count   = 0;
    int reply_count   = 0;
    int n_steps       = 0;
    int n_places      = 0;
    int n_clears      = 0;
    int n_reads       = 0;
    int n_read_ones   = 0;
    int grains_moved  = 0;
    int input_stalls  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // All block inputs start at known values; reset is released once.
    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_STEP;
        req_ch.x      = '0;
        req_ch.y      = '0;
        rsp_ch.ready  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Generous limit: even if every request were a full generation and every
    // response sat through a long stall, the run stays well inside this.
    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One full generation on the local grid. Columns are scanned right to
    // left and rows bottom to top, in place, so a grain that slides
    // below-left lands in a column that is still to be scanned and may move
    // again in the same pass. The floor row and the border cells never move.
    function automatic void run_sand_generation();
        for (int c = LAST_COL - 1; c > 0; c--)
        begin
            for (int r = LAST_ROW - 1; r > 0; r--)
            begin
                if (!sand_cols[c][r] || r == LAST_ROW - 1)
                    continue;
                if (!sand_cols[c][r+1])
                begin
                    sand_cols[c][r]   = 1'b0;
                    sand_cols[c][r+1] = 1'b1;
                    grains_moved++;
                end
                else if (!sand_cols[c-1][r+1])
                begin
                    sand_cols[c][r]     = 1'b0;
                    sand_cols[c-1][r+1] = 1'b1;
                    grains_moved++;
                end
                else if (!sand_cols[c+1][r+1])
                begin
                    sand_cols[c][r]     = 1'b0;
                    sand_cols[c+1][r+1] = 1'b1;
                    grains_moved++;
                end
            end
        end
    endfunction

    // Applies one accepted request to the local grid and returns the
    // response the block must give for it.
    function automatic sand_reply_t predict_sand_reply(fsg_func_t op,
                                                       logic [XY_W-1:0] cx,
                                                       logic [XY_W-1:0] ry);
        sand_reply_t rep;
        rep = '0;
        case (op)
            FUNC_STEP:
            begin
                run_sand_generation();
                n_steps++;
            end
            FUNC_PLACE:
            begin
                // Column 0 and row 0 are off limits for placing grains.
                if (cx != 0 && ry != 0 && int'(cx) <= LAST_COL && int'(ry) <= LAST_ROW)
                begin
                    sand_cols[cx][ry] = 1'b1;
                    rep.placed = 1'b1;
                end
                n_places++;
            end
            FUNC_CLEAR:
            begin
                // The whole grid goes, last column and last row included.
                foreach (sand_cols[c])
                    sand_cols[c] = '0;
                n_clears++;
            end
            FUNC_READ:
            begin
                if (int'(cx) <= LAST_COL && int'(ry) <= LAST_ROW)
                    rep.cell_value = sand_cols[cx][ry];
                n_reads++;
                if (rep.cell_value)
                    n_read_ones++;
            end
        endcase
        return rep;
    endfunction

    // Offers one request, holding it until the block takes it, and records
    // the expected response at the edge of acceptance. Valid is left high
    // so back-to-back requests need only one assignment per edge.
    task automatic send_request(fsg_func_t op, logic [XY_W-1:0] cx, logic [XY_W-1:0] ry);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.x     <= cx;
        req_ch.y     <= ry;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        pending_replies.push_back(predict_sand_reply(op, cx, ry));
    endtask

    // Response side: either a forced hold-off, counted down here, or a
    // random stall at the rate of the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (rsp_hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left = rsp_hold_left - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Response checker: each accepted response is matched against the
    // oldest outstanding expectation, field by field.
    always @(posedge clk)
    begin
        sand_reply_t exp_rep;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            reply_count++;
            if (pending_replies.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: response %0d arrived with no request outstanding",
                             reply_count);
            end
            else
            begin
                exp_rep = pending_replies.pop_front();
                if (rsp_ch.cell_value !== exp_rep.cell_value ||
                    rsp_ch.placed !== exp_rep.placed)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"ERROR: response %0d: cell_value exp %0b got %0b, ",
                                  "placed exp %0b got %0b"},
                                 reply_count, exp_rep.cell_value, rsp_ch.cell_value,
                                 exp_rep.placed, rsp_ch.placed);
                end
            end
        end
    end

    // Mostly well-formed sand play around one cluster of columns: grains are
    // dropped low in the grid so that the generations in between pile them
    // up and exercise the diagonal slides. About a tenth of the requests
    // are noise anywhere in the full field range, which also reaches the
    // edge cases on the outer rows and columns.
    task automatic random_grid_traffic(int count);
        int               base_col;
        int               pick;
        logic [XY_W-1:0]  cx;
        logic [XY_W-1:0]  ry;
        base_col = $urandom_range(1, 56);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_request(FUNC_CLEAR, XY_W'($urandom_range(63)), XY_W'($urandom_range(63)));
            else if (pick < 28)
                send_request(FUNC_STEP, XY_W'($urandom_range(63)), XY_W'($urandom_range(63)));
            else if (pick < 68)
            begin
                cx = XY_W'(base_col + $urandom_range(0, 6));
                ry = XY_W'($urandom_range(44, 62));
                send_request(FUNC_PLACE, cx, ry);
            end
            else if (pick < 90)
            begin
                cx = XY_W'(base_col - 1 + $urandom_range(0, 8));
                ry = XY_W'($urandom_range(44, 63));
                send_request(FUNC_READ, cx, ry);
            end
            else
                send_request(fsg_func_t'($urandom_range(3)),
                             XY_W'($urandom_range(63)), XY_W'($urandom_range(63)));
        end
    endtask

    // Placing grains: the edge column and edge row are refused, the far
    // corner is accepted, and placing on an already full cell still reports
    // the cell as set.
    task automatic test_place_bounds();
        send_request(FUNC_PLACE, 6'd0, 6'd5);
        send_request(FUNC_PLACE, 6'd5, 6'd0);
        send_request(FUNC_PLACE, 6'd0, 6'd0);
        send_request(FUNC_PLACE, 6'd63, 6'd63);
        send_request(FUNC_PLACE, 6'd63, 6'd63);
        send_request(FUNC_READ, 6'd63, 6'd63);
    endtask

    // Clear must also empty the last column and the last row.
    task automatic test_clear_corner();
        send_request(FUNC_CLEAR, 6'd63, 6'd63);
        send_request(FUNC_READ, 6'd63, 6'd63);
    endtask

    // One generation over hand-built patterns: a grain blocked below that
    // slides below-left, one blocked below and below-left that slides
    // below-right, one in column 1 that slides into the border column, and
    // one that simply falls onto the floor row. Reads then confirm the
    // landing cells.
    task automatic test_single_generation();
        send_request(FUNC_PLACE, 6'd20, 6'd62);
        send_request(FUNC_PLACE, 6'd20, 6'd61);
        send_request(FUNC_PLACE, 6'd30, 6'd62);
        send_request(FUNC_PLACE, 6'd29, 6'd62);
        send_request(FUNC_PLACE, 6'd30, 6'd61);
        send_request(FUNC_PLACE, 6'd1, 6'd62);
        send_request(FUNC_PLACE, 6'd1, 6'd61);
        send_request(FUNC_PLACE, 6'd5, 6'd61);
        send_request(FUNC_STEP, 6'd0, 6'd0);
        send_request(FUNC_READ, 6'd19, 6'd62);
        send_request(FUNC_READ, 6'd31, 6'd62);
        send_request(FUNC_READ, 6'd0, 6'd62);
        send_request(FUNC_READ, 6'd5, 6'd62);
    endtask

    task automatic test_random_no_idle();
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
        random_grid_traffic(28);
    endtask

    task automatic test_random_sender_idle();
        sender_idle_pct = 45;
        rsp_stall_pct   = 0;
        random_grid_traffic(28);
    endtask

    task automatic test_random_receiver_stall();
        sender_idle_pct = 0;
        rsp_stall_pct   = 45;
        random_grid_traffic(28);
    endtask

    task automatic test_random_both_idle();
        sender_idle_pct = 8;
        rsp_stall_pct   = 8;
        random_grid_traffic(27);
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming, so the output register and the engine both fill and the
    // block has to stall its input until the hold ends.
    task automatic test_response_backpressure();
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
        rsp_hold_left   = 300;
        for (int i = 0; i < 8; i++)
        begin
            if (i % 2 == 0)
                send_request(FUNC_PLACE, XY_W'($urandom_range(1, 63)),
                             XY_W'($urandom_range(40, 63)));
            else
                send_request(FUNC_READ, XY_W'($urandom_range(63)), XY_W'($urandom_range(63)));
        end
    endtask

    initial
    begin
        int drain_cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);

        test_place_bounds();
        test_clear_corner();
        test_single_generation();
        test_random_no_idle();
        test_random_sender_idle();
        test_response_backpressure();
        test_random_receiver_stall();
        test_random_both_idle();

        req_ch.valid <= 1'b0;

        // Wait for every outstanding response, with a bound well above one
        // generation plus stalls, then a few more cycles to catch strays.
        drain_cycles = 0;
        while (pending_replies.size() != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_replies.size() != 0)
        begin
            error_count += pending_replies.size();
            $display("ERROR: %0d responses never arrived", pending_replies.size());
        end
        repeat (10) @(posedge clk);

        $display("Covered %0d requests: %0d generations moving %0d grains, %0d places, %0d clears,",
                 n_steps + n_places + n_clears + n_reads, n_steps, grains_moved,
                 n_places, n_clears);
        $display("%0d reads (%0d found sand), %0d input stall cycles, %0d errors",
                 n_reads, n_read_ones, input_stalls, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
